/* design/lcsd_pkg.sv */
// Shared types, constants and tables for the linear / circular standard deviation block.
// Used by every module of the block; depends on nothing else.
package lcsd_pkg;

    localparam int SAMPLE_W         = 24;
    localparam int DEV_W            = 24;
    localparam int NOUT_W           = 11;
    localparam int MAX_SAMPLES_DEF  = 1024;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int XW               = 34;

    localparam logic [DEV_W-1:0]       DEV_MAX          = 24'hFFFFFF;
    localparam logic signed [24:0]     DEG360_Q12       = 25'sd1474560;
    localparam logic signed [24:0]     DEG180_Q12       = 25'sd737280;
    localparam logic signed [24:0]     DEG90_Q12        = 25'sd368640;
    localparam logic [24:0]            RAD_PER_DEG_Q30  = 25'd18740327;
    localparam logic signed [XW-1:0]   CORDIC_GAIN_Q30  = 34'sd652032874;
    localparam logic [30:0]            HALF_PI_Q30      = 31'd1686629713;
    localparam logic [63:0]            YAMARTINO_B_Q30  = 64'd166107860;
    localparam logic [63:0]            DEG_PER_RAD_Q24  = 64'd961263808;
    localparam logic [63:0]            ONE_Q30          = 64'h0000_0000_4000_0000;
    localparam logic [127:0]           ONE_Q32          = 128'h1_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_ACC, ST_REDUCE, ST_FOLD, ST_ANGLE,
        ST_LAUNCH, ST_WAIT, ST_DECIDE, ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        STEP_ROT, STEP_L_SQ, STEP_L_MAG, STEP_L_DIV, STEP_L_SQRT,
        STEP_C_SS, STEP_C_CC, STEP_C_DIV, STEP_C_SQE, STEP_C_SQR, STEP_C_VEC,
        STEP_C_E2, STEP_C_E3, STEP_C_FAC, STEP_C_ANG, STEP_C_DEG
    } step_t;

    typedef enum logic [1:0] {
        SEQ_MUL, SEQ_DIV, SEQ_SQRT
    } seq_op_t;

    typedef struct packed {
        step_t step;
        logic  load;
        logic  acc;
        logic  reduce;
        logic  fold;
        logic  angle;
        logic  start;
        logic  capture;
        logic  decide;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic take;
        logic last;
        logic in_range;
        logic too_few;
        logic circ;
        logic neg;
        logic over;
        logic unit_done;
    } status_t;

    // atan(2^-i) in Q30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:  r = 32'd843314857;
                5'd1:  r = 32'd497837829;
                5'd2:  r = 32'd263043837;
                5'd3:  r = 32'd133525159;
                5'd4:  r = 32'd67021687;
                5'd5:  r = 32'd33543516;
                5'd6:  r = 32'd16775851;
                5'd7:  r = 32'd8388437;
                5'd8:  r = 32'd4194283;
                5'd9:  r = 32'd2097149;
                5'd10: r = 32'd1048576;
                5'd11: r = 32'd524288;
                5'd12: r = 32'd262144;
                5'd13: r = 32'd131072;
                5'd14: r = 32'd65536;
                5'd15: r = 32'd32768;
                5'd16: r = 32'd16384;
                5'd17: r = 32'd8192;
                5'd18: r = 32'd4096;
                5'd19: r = 32'd2048;
                5'd20: r = 32'd1024;
                5'd21: r = 32'd512;
                5'd22: r = 32'd256;
                5'd23: r = 32'd128;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* design/lcsd_seq.sv */
// Shared iterative arithmetic unit: shift-add multiply, restoring divide, integer square root.
// Depends on lcsd_pkg.
module lcsd_seq import lcsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  seq_op_t       op,
    input  logic [127:0]  a,
    input  logic [63:0]   b,
    output logic [127:0]  res,
    output logic          done
);

    logic          busy_reg;
    logic          done_reg;
    seq_op_t       op_reg;
    logic [6:0]    cnt_reg;
    logic [127:0]  acc_reg;
    logic [127:0]  sh_reg;
    logic [63:0]   bq_reg;
    logic [63:0]   aux_reg;
    logic [31:0]   root_reg;

    logic [64:0]   div_rem;
    logic [35:0]   sq_rem;
    logic [35:0]   sq_trial;

    assign div_rem  = {aux_reg, sh_reg[127]};
    assign sq_rem   = {aux_reg[33:0], sh_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    // control: start, count iterations, pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == 7'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: one bit (or bit pair) per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            acc_reg  <= '0;
            sh_reg   <= a;
            bq_reg   <= b;
            aux_reg  <= '0;
            root_reg <= '0;
            case (op)
                SEQ_MUL:  cnt_reg <= 7'd63;
                SEQ_DIV:  cnt_reg <= 7'd127;
                default:  cnt_reg <= 7'd31;
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            case (op_reg)
                SEQ_MUL:
                begin
                    if (bq_reg[0])
                        acc_reg <= acc_reg + sh_reg;
                    sh_reg <= {sh_reg[126:0], 1'b0};
                    bq_reg <= {1'b0, bq_reg[63:1]};
                end
                SEQ_DIV:
                begin
                    if (div_rem >= {1'b0, bq_reg})
                    begin
                        aux_reg <= 64'(div_rem - {1'b0, bq_reg});
                        sh_reg  <= {sh_reg[126:0], 1'b1};
                    end
                    else
                    begin
                        aux_reg <= div_rem[63:0];
                        sh_reg  <= {sh_reg[126:0], 1'b0};
                    end
                end
                default:
                begin
                    if (sq_rem >= sq_trial)
                    begin
                        aux_reg  <= 64'(sq_rem - sq_trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        aux_reg  <= 64'(sq_rem);
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    sh_reg <= {sh_reg[125:0], 2'b00};
                end
            endcase
        end
    end

    // select result by operation
    always_comb
    begin
        case (op_reg)
            SEQ_MUL: res = acc_reg;
            SEQ_DIV: res = sh_reg;
            default: res = {96'b0, root_reg};
        endcase
    end

    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("arith unit done without a running operation");

endmodule

/* design/lcsd_cordic.sv */
// Iterative CORDIC, rotation and vectoring modes, one micro-rotation per cycle.
// Depends on lcsd_pkg (arctangent table).
module lcsd_cordic import lcsd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 vectoring,
    input  logic signed [XW-1:0] x0,
    input  logic signed [XW-1:0] y0,
    input  logic signed [XW-1:0] z0,
    output logic signed [XW-1:0] x,
    output logic signed [XW-1:0] y,
    output logic signed [XW-1:0] z,
    output logic                 done
);

    localparam int I_W = $clog2(CORDIC_STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 vec_reg;
    logic [I_W-1:0]       i_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [XW-1:0] z_reg;

    logic                 pos;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] ang;

    assign dx  = y_reg >>> i_reg;
    assign dy  = x_reg >>> i_reg;
    assign ang = $signed({2'b00, atan_q30(5'(i_reg))});
    assign pos = vec_reg ? y_reg[XW-1] : !z_reg[XW-1];

    // control: run the configured number of micro-rotations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && i_reg == I_W'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // micro-rotation
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            vec_reg <= vectoring;
            i_reg   <= '0;
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg + I_W'(1);
            if (pos)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
        end
    end

    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
    assign done = done_reg;

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("cordic done without a running rotation");

endmodule

/* design/lcsd_dp.sv */
// Datapath: accumulators, angle reduction, final statistics and result registers.
// Depends on lcsd_pkg, lcsd_seq and lcsd_cordic.
module lcsd_dp import lcsd_pkg::*;
#(
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic                       cfg_wr,
    input  logic                       cfg_data,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       missing,
    input  logic                       last,
    output logic                       done,
    output logic [DEV_W-1:0]           deviation,
    output logic                       undefined,
    output logic [NOUT_W-1:0]          valid_samples
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int VSUM_W = SAMPLE_W + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_W - 1 + CNT_W;
    localparam int TRIG_W = 18 + CNT_W;

    // state registers
    logic                       mode_reg;
    logic [CNT_W-1:0]           count_reg;
    logic signed [VSUM_W-1:0]   vsum_reg;
    logic [SQ_W-1:0]            sqsum_reg;
    logic signed [TRIG_W-1:0]   ssum_reg;
    logic signed [TRIG_W-1:0]   csum_reg;
    logic                       done_reg;

    // working registers
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic                       miss_reg;
    logic                       last_reg;
    logic signed [24:0]         r_reg;
    logic                       flip_reg;
    logic signed [XW-1:0]       zin_reg;
    logic [127:0]               t0_reg;
    logic [30:0]                e_reg;
    logic [30:0]                rr_reg;
    logic [30:0]                ang_reg;
    logic [63:0]                k_reg;
    logic [DEV_W-1:0]           dev_reg;
    logic                       undef_reg;
    logic [DEV_W-1:0]           deviation_reg;
    logic                       undefined_reg;
    logic [NOUT_W-1:0]          nout_reg;

    // unit connections
    logic                       seq_start;
    seq_op_t                    seq_op;
    logic [127:0]               seq_a;
    logic [63:0]                seq_b;
    logic [127:0]               seq_res;
    logic                       seq_done;
    logic                       cor_start;
    logic                       cor_vec;
    logic signed [XW-1:0]       cor_x0;
    logic signed [XW-1:0]       cor_y0;
    logic signed [XW-1:0]       cor_z0;
    logic signed [XW-1:0]       cor_x;
    logic signed [XW-1:0]       cor_y;
    logic signed [XW-1:0]       cor_z;
    logic                       cor_done;

    // helpers
    logic [SAMPLE_W-1:0]        smag;
    logic [47:0]                sq;
    logic [VSUM_W-1:0]          vmag;
    logic [TRIG_W-1:0]          sin_mag;
    logic [TRIG_W-1:0]          cos_mag;
    logic [2*CNT_W-1:0]         npair;
    logic [2*CNT_W-1:0]         nsq;
    logic [32:0]                e2;
    logic signed [24:0]         rf;
    logic                       rflip;
    logic [18:0]                amag;
    logic [43:0]                zprod;
    logic [43:0]                zsum;
    logic [127:0]               rnd30;
    logic [127:0]               rnd42;
    logic [63:0]                k30;
    logic [63:0]                deg;
    logic signed [17:0]         sq16;
    logic signed [17:0]         cq16;
    logic [31:0]                nwide;

    function automatic logic signed [17:0] to_q16(input logic signed [XW-1:0] v);
        logic signed [XW:0] t;
        logic signed [20:0] q;
        begin
            t = (XW + 1)'(v) + 35'sd8192;
            q = 21'(t >>> 14);
            if (q > 21'sd65536)
                q = 21'sd65536;
            else if (q < -21'sd65536)
                q = -21'sd65536;
            return 18'(q);
        end
    endfunction

    assign smag    = samp_reg[SAMPLE_W-1] ? SAMPLE_W'(-samp_reg) : SAMPLE_W'(samp_reg);
    assign sq      = {24'b0, smag} * {24'b0, smag};
    assign vmag    = vsum_reg[VSUM_W-1] ? VSUM_W'(-vsum_reg) : VSUM_W'(vsum_reg);
    assign sin_mag = ssum_reg[TRIG_W-1] ? TRIG_W'(-ssum_reg) : TRIG_W'(ssum_reg);
    assign cos_mag = csum_reg[TRIG_W-1] ? TRIG_W'(-csum_reg) : TRIG_W'(csum_reg);
    assign npair   = (2*CNT_W)'(count_reg) * (2*CNT_W)'(count_reg - CNT_W'(1));
    assign nsq     = (2*CNT_W)'(count_reg) * (2*CNT_W)'(count_reg);
    assign e2      = 33'h1_0000_0000 - t0_reg[32:0];
    assign rnd30   = seq_res + {98'b0, 1'b1, 29'b0};
    assign rnd42   = seq_res + {86'b0, 1'b1, 41'b0};
    assign k30     = rnd30[93:30];
    assign deg     = rnd42[105:42];
    assign sq16    = flip_reg ? -to_q16(cor_y) : to_q16(cor_y);
    assign cq16    = flip_reg ? -to_q16(cor_x) : to_q16(cor_x);
    assign nwide   = 32'(count_reg);

    // fold into [-90, 90] degrees
    always_comb
    begin
        rf    = r_reg;
        rflip = 1'b0;
        if (r_reg > DEG90_Q12)
        begin
            rf    = r_reg - DEG180_Q12;
            rflip = 1'b1;
        end
        else if (r_reg < -DEG90_Q12)
        begin
            rf    = r_reg + DEG180_Q12;
            rflip = 1'b1;
        end
    end

    // degrees to radians, rounded
    assign amag  = r_reg[24] ? 19'(-r_reg) : 19'(r_reg);
    assign zprod = 44'(amag) * 44'(RAD_PER_DEG_Q30);
    assign zsum  = zprod + 44'd2048;

    // operands for the shared arithmetic unit
    always_comb
    begin
        seq_op = SEQ_MUL;
        seq_a  = '0;
        seq_b  = '0;
        case (cmd.step)
            STEP_L_SQ:
            begin
                seq_a = 128'(count_reg);
                seq_b = 64'(sqsum_reg);
            end
            STEP_L_MAG:
            begin
                seq_a = 128'(vmag);
                seq_b = 64'(vmag);
            end
            STEP_L_DIV:
            begin
                seq_op = SEQ_DIV;
                seq_a  = t0_reg;
                seq_b  = 64'(npair);
            end
            STEP_L_SQRT:
            begin
                seq_op = SEQ_SQRT;
                seq_a  = {64'b0, t0_reg[63:0]};
            end
            STEP_C_SS:
            begin
                seq_a = 128'(sin_mag);
                seq_b = 64'(sin_mag);
            end
            STEP_C_CC:
            begin
                seq_a = 128'(cos_mag);
                seq_b = 64'(cos_mag);
            end
            STEP_C_DIV:
            begin
                seq_op = SEQ_DIV;
                seq_a  = t0_reg;
                seq_b  = 64'(nsq);
            end
            STEP_C_SQE:
            begin
                seq_op = SEQ_SQRT;
                seq_a  = {67'b0, e2, 28'b0};
            end
            STEP_C_SQR:
            begin
                seq_op = SEQ_SQRT;
                seq_a  = {67'b0, t0_reg[32:0], 28'b0};
            end
            STEP_C_E2:
            begin
                seq_a = 128'(e_reg);
                seq_b = 64'(e_reg);
            end
            STEP_C_E3:
            begin
                seq_a = 128'(k_reg);
                seq_b = 64'(e_reg);
            end
            STEP_C_FAC:
            begin
                seq_a = 128'(k_reg);
                seq_b = YAMARTINO_B_Q30;
            end
            STEP_C_ANG:
            begin
                seq_a = 128'(ang_reg);
                seq_b = k_reg;
            end
            STEP_C_DEG:
            begin
                seq_a = 128'(k_reg);
                seq_b = DEG_PER_RAD_Q24;
            end
            default:
            begin
                seq_a = '0;
                seq_b = '0;
            end
        endcase
    end

    assign cor_vec   = (cmd.step == STEP_C_VEC);
    assign cor_start = cmd.start && (cmd.step == STEP_ROT || cmd.step == STEP_C_VEC);
    assign seq_start = cmd.start && !(cmd.step == STEP_ROT || cmd.step == STEP_C_VEC);
    assign cor_x0    = cor_vec ? $signed({3'b000, rr_reg}) : CORDIC_GAIN_Q30;
    assign cor_y0    = cor_vec ? $signed({3'b000, e_reg}) : '0;
    assign cor_z0    = cor_vec ? '0 : zin_reg;

    lcsd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_start),
        .op    (seq_op),
        .a     (seq_a),
        .b     (seq_b),
        .res   (seq_res),
        .done  (seq_done)
    );

    lcsd_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cor_start),
        .vectoring (cor_vec),
        .x0        (cor_x0),
        .y0        (cor_y0),
        .z0        (cor_z0),
        .x         (cor_x),
        .y         (cor_y),
        .z         (cor_z),
        .done      (cor_done)
    );

    // mode, accumulators and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
            vsum_reg  <= '0;
            sqsum_reg <= '0;
            ssum_reg  <= '0;
            csum_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cfg_wr)
                mode_reg <= cfg_data;
            if (cmd.acc)
            begin
                count_reg <= count_reg + CNT_W'(1);
                vsum_reg  <= vsum_reg + VSUM_W'(samp_reg);
                sqsum_reg <= sqsum_reg + SQ_W'(sq);
            end
            if (cmd.capture && cmd.step == STEP_ROT)
            begin
                ssum_reg <= ssum_reg + TRIG_W'(sq16);
                csum_reg <= csum_reg + TRIG_W'(cq16);
            end
            if (cmd.emit)
            begin
                count_reg <= '0;
                vsum_reg  <= '0;
                sqsum_reg <= '0;
                ssum_reg  <= '0;
                csum_reg  <= '0;
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            samp_reg <= sample;
            miss_reg <= missing;
            last_reg <= last;
        end
        if (cmd.acc)
            r_reg <= 25'(samp_reg);
        if (cmd.reduce)
        begin
            if (r_reg >= DEG180_Q12)
                r_reg <= r_reg - DEG360_Q12;
            else
                r_reg <= r_reg + DEG360_Q12;
        end
        if (cmd.fold)
        begin
            r_reg    <= rf;
            flip_reg <= rflip;
        end
        if (cmd.angle)
            zin_reg <= r_reg[24] ? -XW'(zsum[43:12]) : XW'(zsum[43:12]);
        if (cmd.decide)
        begin
            dev_reg   <= '0;
            undef_reg <= status.too_few;
        end
        if (cmd.capture)
        begin
            case (cmd.step)
                STEP_L_SQ, STEP_C_SS:
                    t0_reg <= seq_res;
                STEP_L_MAG:
                    if (status.neg)
                        dev_reg <= '0;
                    else
                        t0_reg <= t0_reg - seq_res;
                STEP_L_DIV:
                begin
                    t0_reg <= seq_res;
                    if (status.over)
                        dev_reg <= DEV_MAX;
                end
                STEP_L_SQRT:
                    dev_reg <= (seq_res[31:0] > 32'(DEV_MAX)) ? DEV_MAX : seq_res[DEV_W-1:0];
                STEP_C_CC:
                    t0_reg <= t0_reg + seq_res;
                STEP_C_DIV:
                    t0_reg <= (seq_res > ONE_Q32) ? ONE_Q32 : seq_res;
                STEP_C_SQE:
                    e_reg <= seq_res[30:0];
                STEP_C_SQR:
                    rr_reg <= seq_res[30:0];
                STEP_C_VEC:
                    if (cor_z[XW-1])
                        ang_reg <= '0;
                    else if (cor_z > $signed({3'b000, HALF_PI_Q30}))
                        ang_reg <= HALF_PI_Q30;
                    else
                        ang_reg <= cor_z[30:0];
                STEP_C_E2, STEP_C_E3, STEP_C_ANG:
                    k_reg <= k30;
                STEP_C_FAC:
                    k_reg <= ONE_Q30 + k30;
                STEP_C_DEG:
                    dev_reg <= (deg > 64'(DEV_MAX)) ? DEV_MAX : deg[DEV_W-1:0];
                default:
                    k_reg <= k_reg;
            endcase
        end
        if (cmd.emit)
        begin
            deviation_reg <= dev_reg;
            undefined_reg <= undef_reg;
            nout_reg      <= nwide[NOUT_W-1:0];
        end
    end

    // status back to the controller
    always_comb
    begin
        status           = '0;
        status.take      = !miss_reg && (count_reg < CNT_W'(MAX_SAMPLES));
        status.last      = last_reg;
        status.in_range  = (r_reg < DEG180_Q12) && (r_reg >= -DEG180_Q12);
        status.too_few   = mode_reg ? (count_reg == '0) : (count_reg < CNT_W'(2));
        status.circ      = mode_reg;
        status.neg       = seq_res > t0_reg;
        status.over      = |seq_res[127:64];
        status.unit_done = seq_done | cor_done;
    end

    assign done          = done_reg;
    assign deviation     = deviation_reg;
    assign undefined     = undefined_reg;
    assign valid_samples = nout_reg;

endmodule

/* design/lcsd_ctrl.sv */
// Controller state machine: sequences per-word accumulation and the final statistic.
// Depends on lcsd_pkg.
module lcsd_ctrl import lcsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    step_t       step_reg;
    step_t       step_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_ROT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            ST_CHECK:
                if (status.take)
                    state_next = ST_ACC;
                else if (status.last)
                    state_next = ST_DECIDE;
                else
                    state_next = ST_IDLE;
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
                if (status.in_range)
                    state_next = ST_FOLD;
                else
                    cmd.reduce = 1'b1;
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                cmd.angle  = 1'b1;
                step_next  = STEP_ROT;
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
                if (status.unit_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LAUNCH;
                    unique case (step_reg)
                        STEP_ROT:    state_next = status.last ? ST_DECIDE : ST_IDLE;
                        STEP_L_SQ:   step_next = STEP_L_MAG;
                        STEP_L_MAG:
                            if (status.neg)
                                state_next = ST_EMIT;
                            else
                                step_next = STEP_L_DIV;
                        STEP_L_DIV:
                            if (status.over)
                                state_next = ST_EMIT;
                            else
                                step_next = STEP_L_SQRT;
                        STEP_L_SQRT: state_next = ST_EMIT;
                        STEP_C_SS:   step_next = STEP_C_CC;
                        STEP_C_CC:   step_next = STEP_C_DIV;
                        STEP_C_DIV:  step_next = STEP_C_SQE;
                        STEP_C_SQE:  step_next = STEP_C_SQR;
                        STEP_C_SQR:  step_next = STEP_C_VEC;
                        STEP_C_VEC:  step_next = STEP_C_E2;
                        STEP_C_E2:   step_next = STEP_C_E3;
                        STEP_C_E3:   step_next = STEP_C_FAC;
                        STEP_C_FAC:  step_next = STEP_C_ANG;
                        STEP_C_ANG:  step_next = STEP_C_DEG;
                        STEP_C_DEG:  state_next = ST_EMIT;
                        default:     state_next = ST_EMIT;
                    endcase
                end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.too_few)
                    state_next = ST_EMIT;
                else
                begin
                    step_next  = status.circ ? STEP_C_SS : STEP_L_SQ;
                    state_next = ST_LAUNCH;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after a result");

endmodule

/* design/linear_or_circular_std_deviation.sv */
// Top level of the linear / circular standard deviation block.
// Depends on lcsd_pkg, lcsd_ctrl and lcsd_dp.
//
// Usage:
//   Input words are offered on sample/missing/last and taken at a clock edge with
//   start high and busy low. Missing samples are skipped; a word with last set
//   closes the set. cfg_wr/cfg_data write the circular_mode register; the user must
//   write it only while idle, which the block does not enforce. One result word per
//   set appears on deviation/undefined/valid_samples for exactly one cycle with done
//   high; the receiver cannot stall it.
// Processing:
//   A counted sample is accumulated, then its angle is reduced one full turn per step
//   (at most six), folded, converted to radians and rotated by the CORDIC. The closing
//   step runs on the shared bit-serial arithmetic unit: two multiplies, a divide and a
//   root in linear mode; circular mode adds more multiplies, a root and a CORDIC pass.
// Reset:
//   rst_n clears the mode to linear and empties all accumulators; the block is
//   ready for a word as soon as reset is released.
module linear_or_circular_std_deviation import lcsd_pkg::*;
#(
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       missing,
    input  logic                       last,
    input  logic                       cfg_wr,
    input  logic                       cfg_data,
    output logic                       done,
    output logic [DEV_W-1:0]           deviation,
    output logic                       undefined,
    output logic [NOUT_W-1:0]          valid_samples
);

    cmd_t    cmd;
    status_t status;

    lcsd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lcsd_dp #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr        (cfg_wr),
        .cfg_data      (cfg_data),
        .sample        (sample),
        .missing       (missing),
        .last          (last),
        .done          (done),
        .deviation     (deviation),
        .undefined     (undefined),
        .valid_samples (valid_samples)
    );

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

endmodule
